/* rtl/core/fbfa_pkg.sv */
// Shared types and constants for the first/best-fit segment allocator.
// No dependencies; every other file takes names from here, by scope or by import.
`default_nettype none
package fbfa_pkg;

    localparam int MAX_EXTENTS  = 64;
    localparam int HEADER_BYTES = 16;
    localparam int IDX_W        = $clog2(MAX_EXTENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ADDR_W       = 32;
    localparam int SIZE_W       = 24;
    localparam int CFG_IDX_W    = 1;

    localparam logic [ADDR_W-1:0] HDR = ADDR_W'(HEADER_BYTES);

    // request commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [1:0] ST_TAKEN   = 2'd0;
    localparam logic [1:0] ST_BREAK   = 2'd1;
    localparam logic [1:0] ST_FREED   = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 1'b1;

    localparam logic FIT_FIRST = 1'b0;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
    } entry_t;

    // datapath operations
    typedef logic [4:0] dp_op_t;
    localparam dp_op_t OP_NOP       = 5'd0;
    localparam dp_op_t OP_LOAD      = 5'd1;
    localparam dp_op_t OP_DROP      = 5'd2;
    localparam dp_op_t OP_READ      = 5'd3;
    localparam dp_op_t OP_EVAL      = 5'd4;
    localparam dp_op_t OP_SEL_HIT   = 5'd5;
    localparam dp_op_t OP_SEL_BEST  = 5'd6;
    localparam dp_op_t OP_SPLIT_SUB = 5'd7;
    localparam dp_op_t OP_SPLIT_WR  = 5'd8;
    localparam dp_op_t OP_EXACT     = 5'd9;
    localparam dp_op_t OP_BREAK     = 5'd10;
    localparam dp_op_t OP_STEP_PREV = 5'd11;
    localparam dp_op_t OP_SET_POS   = 5'd12;
    localparam dp_op_t OP_SET_END   = 5'd13;
    localparam dp_op_t OP_FREE_CHK  = 5'd14;
    localparam dp_op_t OP_FREE_ADDP = 5'd15;
    localparam dp_op_t OP_FREE_WR   = 5'd16;
    localparam dp_op_t OP_READ_NEXT = 5'd17;
    localparam dp_op_t OP_SHD_WR    = 5'd18;
    localparam dp_op_t OP_SHD_DONE  = 5'd19;
    localparam dp_op_t OP_READ_PREV = 5'd20;
    localparam dp_op_t OP_SHU_WR    = 5'd21;
    localparam dp_op_t OP_SHU_INS   = 5'd22;
    localparam dp_op_t OP_PUBLISH   = 5'd23;

    typedef struct packed {
        logic is_free;
        logic table_full;
        logic scan_end;
        logic exact;
        logic split_first;
        logic best_valid;
        logic at_ge;
        logic merge_next;
        logic merge_prev;
        logic shd_end;
        logic shu_end;
        logic out_busy;
    } dp_status_t;

endpackage
`default_nettype wire

/* rtl/core/fbfa_if.sv */
// Request, result and configuration channel interfaces.
// Depends on fbfa_pkg for field widths.
`default_nettype none
interface fbfa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [fbfa_pkg::SIZE_W-1:0]   req_size;
    logic [fbfa_pkg::ADDR_W-1:0]   block_addr;
    logic [fbfa_pkg::SIZE_W-1:0]   block_bytes;
    modport source (output valid, cmd, req_size, block_addr, block_bytes, input ready);
    modport sink   (input valid, cmd, req_size, block_addr, block_bytes, output ready);
endinterface

interface fbfa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fbfa_pkg::ADDR_W-1:0]   payload_addr;
    logic [1:0]                    status;
    logic [fbfa_pkg::ADDR_W-1:0]   free_total;
    logic [fbfa_pkg::ADDR_W-1:0]   used_total;
    modport source (output valid, payload_addr, status, free_total, used_total, input ready);
    modport sink   (input valid, payload_addr, status, free_total, used_total, output ready);
endinterface

interface fbfa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fbfa_pkg::CFG_IDX_W-1:0] reg_index;
    logic [fbfa_pkg::ADDR_W-1:0]    data;
    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/fbfa_datapath.sv */
// Allocator datapath: extent table memory, heap state, scan and shift registers.
// Depends on fbfa_pkg; driven by fbfa_ctrl through dp_op_t commands.
`default_nettype none
module fbfa_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fbfa_pkg::dp_op_t               op,
    output fbfa_pkg::dp_status_t           status,
    input  logic                           cmd,
    input  logic [fbfa_pkg::SIZE_W-1:0]    req_size,
    input  logic [fbfa_pkg::ADDR_W-1:0]    block_addr,
    input  logic [fbfa_pkg::SIZE_W-1:0]    block_bytes,
    input  logic                           cfg_we,
    input  logic [fbfa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [fbfa_pkg::ADDR_W-1:0]    cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [fbfa_pkg::ADDR_W-1:0]    out_addr,
    output logic [1:0]                     out_status,
    output logic [fbfa_pkg::ADDR_W-1:0]    out_free,
    output logic [fbfa_pkg::ADDR_W-1:0]    out_used
);

    fbfa_pkg::entry_t mem [fbfa_pkg::MAX_EXTENTS];

    // architectural state
    logic                          fit_mode_reg;
    logic [fbfa_pkg::ADDR_W-1:0]   heap_base_reg;
    logic [fbfa_pkg::CNT_W-1:0]    count_reg;
    logic [fbfa_pkg::ADDR_W-1:0]   brk_reg;
    logic                          loaded_reg;
    logic [fbfa_pkg::ADDR_W-1:0]   free_sum_reg;
    logic                          out_valid_reg;

    // per-request working registers
    logic                          is_free_reg;
    logic [fbfa_pkg::ADDR_W-1:0]   need_reg;
    logic [fbfa_pkg::ADDR_W-1:0]   start_reg;
    logic [fbfa_pkg::ADDR_W-1:0]   bytes_reg;
    logic [fbfa_pkg::CNT_W-1:0]    idx_reg;
    logic [fbfa_pkg::CNT_W-1:0]    pos_reg;
    fbfa_pkg::entry_t              rdata_reg;
    fbfa_pkg::entry_t              sel_reg;
    logic [fbfa_pkg::CNT_W-1:0]    sel_idx_reg;
    logic                          best_valid_reg;
    logic [fbfa_pkg::CNT_W-1:0]    best_idx_reg;
    fbfa_pkg::entry_t              best_reg;
    logic [fbfa_pkg::ADDR_W-1:0]   min_excess_reg;
    fbfa_pkg::entry_t              prev_reg;
    logic                          prev_valid_reg;
    fbfa_pkg::entry_t              next_reg;
    logic                          next_valid_reg;
    logic                          mn_reg;
    logic                          mp_reg;
    logic [fbfa_pkg::ADDR_W-1:0]   acc_reg;
    logic [fbfa_pkg::ADDR_W-1:0]   res_addr_reg;
    logic [1:0]                    res_status_reg;

    logic [fbfa_pkg::ADDR_W-1:0]   diff;
    logic                          exact;
    logic                          split;
    logic                          merge_next;
    logic [fbfa_pkg::CNT_W-1:0]    idx_inc;
    logic [fbfa_pkg::CNT_W-1:0]    idx_dec;
    logic                          wr_en;
    logic [fbfa_pkg::IDX_W-1:0]    wr_addr;
    fbfa_pkg::entry_t              wr_data;
    logic                          rd_en;
    logic [fbfa_pkg::IDX_W-1:0]    rd_addr;
    logic [fbfa_pkg::ADDR_W-1:0]   used;

    assign diff       = rdata_reg.size - need_reg;
    assign exact      = rdata_reg.size == need_reg;
    assign split      = (rdata_reg.size > need_reg) && (diff > fbfa_pkg::HDR);
    assign merge_next = next_valid_reg && ((start_reg + bytes_reg) == next_reg.start);
    assign idx_inc    = idx_reg + 1'b1;
    assign idx_dec    = idx_reg - 1'b1;
    assign used       = (loaded_reg ? brk_reg - heap_base_reg : brk_reg) - free_sum_reg;

    always_comb
    begin
        status.is_free     = is_free_reg;
        status.table_full  = count_reg >= fbfa_pkg::CNT_W'(fbfa_pkg::MAX_EXTENTS);
        status.scan_end    = idx_reg == count_reg;
        status.exact       = exact;
        status.split_first = split && (fit_mode_reg == fbfa_pkg::FIT_FIRST);
        status.best_valid  = best_valid_reg;
        status.at_ge       = rdata_reg.start >= start_reg;
        status.merge_next  = mn_reg;
        status.merge_prev  = mp_reg;
        status.shd_end     = {1'b0, idx_inc} >= {1'b0, count_reg};
        status.shu_end     = idx_reg == pos_reg;
        status.out_busy    = out_valid_reg && !out_ready;
    end

    // memory port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[fbfa_pkg::IDX_W-1:0];
        wr_en   = 1'b0;
        wr_addr = idx_reg[fbfa_pkg::IDX_W-1:0];
        wr_data = rdata_reg;
        case (op)
            fbfa_pkg::OP_READ:
            begin
                rd_en = 1'b1;
            end
            fbfa_pkg::OP_READ_NEXT:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_inc[fbfa_pkg::IDX_W-1:0];
            end
            fbfa_pkg::OP_READ_PREV:
            begin
                rd_en   = 1'b1;
                rd_addr = idx_dec[fbfa_pkg::IDX_W-1:0];
            end
            fbfa_pkg::OP_SHD_WR, fbfa_pkg::OP_SHU_WR:
            begin
                wr_en = 1'b1;
            end
            fbfa_pkg::OP_SPLIT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = sel_idx_reg[fbfa_pkg::IDX_W-1:0];
                wr_data = sel_reg;
            end
            fbfa_pkg::OP_FREE_WR:
            begin
                wr_en = 1'b1;
                if (mp_reg)
                begin
                    wr_addr = idx_dec[fbfa_pkg::IDX_W-1:0];
                    wr_data = '{start: prev_reg.start, size: acc_reg};
                end
                else
                begin
                    wr_addr = pos_reg[fbfa_pkg::IDX_W-1:0];
                    wr_data = '{start: start_reg, size: acc_reg};
                end
            end
            fbfa_pkg::OP_SHU_INS:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[fbfa_pkg::IDX_W-1:0];
                wr_data = '{start: start_reg, size: acc_reg};
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg  <= 1'b0;
            heap_base_reg <= '0;
            count_reg     <= '0;
            brk_reg       <= '0;
            loaded_reg    <= 1'b0;
            free_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fbfa_pkg::CFG_FIT_MODE:  fit_mode_reg  <= cfg_data[0];
                    fbfa_pkg::CFG_HEAP_BASE: heap_base_reg <= cfg_data;
                    default:                 fit_mode_reg  <= fit_mode_reg;
                endcase
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (op)
                fbfa_pkg::OP_LOAD:
                begin
                    if (cmd == fbfa_pkg::CMD_ALLOC && !loaded_reg)
                    begin
                        brk_reg    <= heap_base_reg;
                        loaded_reg <= 1'b1;
                    end
                end
                fbfa_pkg::OP_SPLIT_WR, fbfa_pkg::OP_EXACT:
                begin
                    free_sum_reg <= free_sum_reg - need_reg;
                end
                fbfa_pkg::OP_BREAK:
                begin
                    brk_reg <= brk_reg + need_reg;
                end
                fbfa_pkg::OP_FREE_CHK:
                begin
                    free_sum_reg <= free_sum_reg + bytes_reg;
                end
                fbfa_pkg::OP_SHD_DONE:
                begin
                    count_reg <= count_reg - 1'b1;
                end
                fbfa_pkg::OP_SHU_INS:
                begin
                    count_reg <= count_reg + 1'b1;
                end
                fbfa_pkg::OP_PUBLISH:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (op)
            fbfa_pkg::OP_LOAD:
            begin
                is_free_reg    <= cmd == fbfa_pkg::CMD_FREE;
                need_reg       <= fbfa_pkg::ADDR_W'(req_size) + fbfa_pkg::HDR;
                start_reg      <= block_addr - fbfa_pkg::HDR;
                bytes_reg      <= fbfa_pkg::ADDR_W'(block_bytes);
                idx_reg        <= '0;
                best_valid_reg <= 1'b0;
                prev_valid_reg <= 1'b0;
            end
            fbfa_pkg::OP_DROP:
            begin
                res_addr_reg   <= '0;
                res_status_reg <= fbfa_pkg::ST_DROPPED;
            end
            fbfa_pkg::OP_EVAL:
            begin
                if (split && (!best_valid_reg || diff < min_excess_reg))
                begin
                    best_valid_reg <= 1'b1;
                    best_idx_reg   <= idx_reg;
                    best_reg       <= rdata_reg;
                    min_excess_reg <= diff;
                end
                idx_reg <= idx_inc;
            end
            fbfa_pkg::OP_SEL_HIT:
            begin
                sel_reg     <= rdata_reg;
                sel_idx_reg <= idx_reg;
            end
            fbfa_pkg::OP_SEL_BEST:
            begin
                sel_reg     <= best_reg;
                sel_idx_reg <= best_idx_reg;
            end
            fbfa_pkg::OP_SPLIT_SUB:
            begin
                sel_reg.size <= sel_reg.size - need_reg;
            end
            fbfa_pkg::OP_SPLIT_WR:
            begin
                res_addr_reg   <= sel_reg.start + sel_reg.size + fbfa_pkg::HDR;
                res_status_reg <= fbfa_pkg::ST_TAKEN;
            end
            fbfa_pkg::OP_EXACT:
            begin
                res_addr_reg   <= sel_reg.start + fbfa_pkg::HDR;
                res_status_reg <= fbfa_pkg::ST_TAKEN;
                idx_reg        <= sel_idx_reg;
            end
            fbfa_pkg::OP_BREAK:
            begin
                res_addr_reg   <= brk_reg + fbfa_pkg::HDR;
                res_status_reg <= fbfa_pkg::ST_BREAK;
            end
            fbfa_pkg::OP_STEP_PREV:
            begin
                prev_reg       <= rdata_reg;
                prev_valid_reg <= 1'b1;
                idx_reg        <= idx_inc;
            end
            fbfa_pkg::OP_SET_POS:
            begin
                pos_reg        <= idx_reg;
                next_reg       <= rdata_reg;
                next_valid_reg <= 1'b1;
            end
            fbfa_pkg::OP_SET_END:
            begin
                pos_reg        <= idx_reg;
                next_valid_reg <= 1'b0;
            end
            fbfa_pkg::OP_FREE_CHK:
            begin
                mn_reg         <= merge_next;
                mp_reg         <= prev_valid_reg
                                  && ((prev_reg.start + prev_reg.size) == start_reg);
                acc_reg        <= merge_next ? bytes_reg + next_reg.size : bytes_reg;
                res_addr_reg   <= '0;
                res_status_reg <= fbfa_pkg::ST_FREED;
            end
            fbfa_pkg::OP_FREE_ADDP:
            begin
                if (mp_reg)
                begin
                    acc_reg <= acc_reg + prev_reg.size;
                end
                // idx tracks pos for the merge write, count for an insert
                idx_reg <= (mn_reg || mp_reg) ? pos_reg : count_reg;
            end
            fbfa_pkg::OP_SHD_WR:
            begin
                idx_reg <= idx_inc;
            end
            fbfa_pkg::OP_SHU_WR:
            begin
                idx_reg <= idx_dec;
            end
            fbfa_pkg::OP_PUBLISH:
            begin
                out_addr   <= res_addr_reg;
                out_status <= res_status_reg;
                out_free   <= free_sum_reg;
                out_used   <= used;
            end
            default:
            begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* rtl/core/fbfa_ctrl.sv */
// Allocator sequencer: walks the extent table and drives datapath commands.
// Depends on fbfa_pkg; pairs with fbfa_datapath.
`default_nettype none
module fbfa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output fbfa_pkg::dp_op_t      op,
    input  fbfa_pkg::dp_status_t  status
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LOAD      = 4'd1;
    localparam logic [3:0] S_SCAN_RD   = 4'd2;
    localparam logic [3:0] S_SCAN_EV   = 4'd3;
    localparam logic [3:0] S_SPLIT_SUB = 4'd4;
    localparam logic [3:0] S_SPLIT_WR  = 4'd5;
    localparam logic [3:0] S_EXACT     = 4'd6;
    localparam logic [3:0] S_BREAK     = 4'd7;
    localparam logic [3:0] S_FREE_CHK  = 4'd8;
    localparam logic [3:0] S_FREE_ADDP = 4'd9;
    localparam logic [3:0] S_FREE_WR   = 4'd10;
    localparam logic [3:0] S_SHD_RD    = 4'd11;
    localparam logic [3:0] S_SHD_WR    = 4'd12;
    localparam logic [3:0] S_SHU_RD    = 4'd13;
    localparam logic [3:0] S_SHU_WR    = 4'd14;
    localparam logic [3:0] S_DONE      = 4'd15;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign req_ready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        op         = fbfa_pkg::OP_NOP;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op         = fbfa_pkg::OP_LOAD;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (status.is_free && status.table_full)
                begin
                    op         = fbfa_pkg::OP_DROP;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (!status.scan_end)
                begin
                    op         = fbfa_pkg::OP_READ;
                    state_next = S_SCAN_EV;
                end
                else if (status.is_free)
                begin
                    op         = fbfa_pkg::OP_SET_END;
                    state_next = S_FREE_CHK;
                end
                else if (status.best_valid)
                begin
                    op         = fbfa_pkg::OP_SEL_BEST;
                    state_next = S_SPLIT_SUB;
                end
                else
                begin
                    state_next = S_BREAK;
                end
            end
            S_SCAN_EV:
            begin
                if (status.is_free)
                begin
                    if (status.at_ge)
                    begin
                        op         = fbfa_pkg::OP_SET_POS;
                        state_next = S_FREE_CHK;
                    end
                    else
                    begin
                        op         = fbfa_pkg::OP_STEP_PREV;
                        state_next = S_SCAN_RD;
                    end
                end
                else if (status.exact)
                begin
                    op         = fbfa_pkg::OP_SEL_HIT;
                    state_next = S_EXACT;
                end
                else if (status.split_first)
                begin
                    op         = fbfa_pkg::OP_SEL_HIT;
                    state_next = S_SPLIT_SUB;
                end
                else
                begin
                    op         = fbfa_pkg::OP_EVAL;
                    state_next = S_SCAN_RD;
                end
            end
            S_SPLIT_SUB:
            begin
                op         = fbfa_pkg::OP_SPLIT_SUB;
                state_next = S_SPLIT_WR;
            end
            S_SPLIT_WR:
            begin
                op         = fbfa_pkg::OP_SPLIT_WR;
                state_next = S_DONE;
            end
            S_EXACT:
            begin
                op         = fbfa_pkg::OP_EXACT;
                state_next = S_SHD_RD;
            end
            S_BREAK:
            begin
                op         = fbfa_pkg::OP_BREAK;
                state_next = S_DONE;
            end
            S_FREE_CHK:
            begin
                op         = fbfa_pkg::OP_FREE_CHK;
                state_next = S_FREE_ADDP;
            end
            S_FREE_ADDP:
            begin
                op = fbfa_pkg::OP_FREE_ADDP;
                // no neighbor merges: open a slot by shifting up
                state_next = (status.merge_next || status.merge_prev) ? S_FREE_WR : S_SHU_RD;
            end
            S_FREE_WR:
            begin
                op = fbfa_pkg::OP_FREE_WR;
                // both sides merged: drop the following entry
                state_next = (status.merge_next && status.merge_prev) ? S_SHD_RD : S_DONE;
            end
            S_SHD_RD:
            begin
                if (status.shd_end)
                begin
                    op         = fbfa_pkg::OP_SHD_DONE;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = fbfa_pkg::OP_READ_NEXT;
                    state_next = S_SHD_WR;
                end
            end
            S_SHD_WR:
            begin
                op         = fbfa_pkg::OP_SHD_WR;
                state_next = S_SHD_RD;
            end
            S_SHU_RD:
            begin
                if (status.shu_end)
                begin
                    op         = fbfa_pkg::OP_SHU_INS;
                    state_next = S_DONE;
                end
                else
                begin
                    op         = fbfa_pkg::OP_READ_PREV;
                    state_next = S_SHU_WR;
                end
            end
            S_SHU_WR:
            begin
                op         = fbfa_pkg::OP_SHU_WR;
                state_next = S_SHU_RD;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    op         = fbfa_pkg::OP_PUBLISH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/first_best_fit_segment_allocator_top.sv */
// A dropped free is answered without reading the extent table. Any other request scans
// the table entry by entry, each entry read and then evaluated, and an insert or
// removal then moves the later entries one at a time, each with a read and a write.
// One request is handled at a time; the extent table memory, used by one operation
// at a time, sets the pace. A finished result waits in the output register, and the next
// request is taken meanwhile.
// Reset: asynchronous, active low; the table empties, break, totals and config clear.
`default_nettype none
module first_best_fit_segment_allocator_top (
    input  logic        clk,
    input  logic        rst_n,
    fbfa_req_if.sink    req,
    fbfa_rsp_if.source  rsp,
    fbfa_cfg_if.sink    cfg
);

    fbfa_pkg::dp_op_t     op;
    fbfa_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    fbfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .op        (op),
        .status    (status)
    );

    fbfa_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .status      (status),
        .cmd         (req.cmd),
        .req_size    (req.req_size),
        .block_addr  (req.block_addr),
        .block_bytes (req.block_bytes),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.reg_index),
        .cfg_data    (cfg.data),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .out_addr    (rsp.payload_addr),
        .out_status  (rsp.status),
        .out_free    (rsp.free_total),
        .out_used    (rsp.used_total)
    );

endmodule
`default_nettype wire

/* rtl/core/fbfa_checker.sv */
// Port-level checks for the allocator top, bound in below.
// Depends on fbfa_pkg and first_best_fit_segment_allocator_top.
`default_nettype none
module fbfa_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic                        req_ready,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [fbfa_pkg::ADDR_W-1:0] payload_addr,
    input  logic [1:0]                  status
);

    // hold a stalled result
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(payload_addr) && $stable(status))
        else $error("stalled result changed");

    // one request in flight: busy right after a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // frees never return an address
    a_free_addr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == fbfa_pkg::ST_FREED || status == fbfa_pkg::ST_DROPPED)
        |-> payload_addr == '0)
        else $error("free result carries an address");

    // a result cannot appear the cycle after its request
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_valid && req_ready))
        else $error("result too early");

endmodule

bind first_best_fit_segment_allocator_top fbfa_checker u_fbfa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .payload_addr (rsp.payload_addr),
    .status       (rsp.status)
);
`default_nettype wire

/* dv/tb_fbfa_if_note.sv */
// Testbench support types for the allocator bench.
// Depends on fbfa_pkg; holds the expected-result record used by tb_top.
`timescale 1ns / 1ps
package tb_fbfa_types;
    import fbfa_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] payload_addr;
        logic [1:0]        status;
        logic [ADDR_W-1:0] free_total;
        logic [ADDR_W-1:0] used_total;
    } alloc_result_t;
endpackage

/* dv/tb_top.sv */
// Self-checking bench for first_best_fit_segment_allocator_top.
// Depends on fbfa_pkg, the fbfa_*_if interfaces and tb_fbfa_types; a shadow
// allocator predicts every result, which is checked in order against the block.
`timescale 1ns / 1ps
module tb_top;
    import fbfa_pkg::*;
    import tb_fbfa_types::*;

    logic clk;
    logic rst_n;

    fbfa_req_if req_ch ();
    fbfa_rsp_if rsp_ch ();
    fbfa_cfg_if cfg_ch ();

    first_best_fit_segment_allocator_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source),
        .cfg   (cfg_ch.sink)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // shadow allocator state
    logic [ADDR_W-1:0] sh_start [$];
    logic [ADDR_W-1:0] sh_size [$];
    logic [ADDR_W-1:0] sh_break;
    logic              sh_loaded;
    logic [ADDR_W-1:0] sh_free;
    logic              sh_fit;
    logic [ADDR_W-1:0] sh_base;

    alloc_result_t pending_results [$];
    int  errors;
    bit  rsp_hold;
    bit  idle_rsp;
    logic [ADDR_W-1:0] live_addr [$];
    logic [SIZE_W-1:0] live_bytes [$];

    function automatic alloc_result_t predict_alloc(logic cmd, logic [SIZE_W-1:0] rsize,
                                                    logic [ADDR_W-1:0] baddr,
                                                    logic [SIZE_W-1:0] bbytes);
        alloc_result_t r;
        logic [ADDR_W-1:0] need;
        logic [ADDR_W-1:0] st;
        logic [ADDR_W-1:0] diff;
        logic [ADDR_W-1:0] min_excess;
        int n;
        int pick;
        int pos;
        r.payload_addr = '0;
        n = sh_start.size();
        if (cmd == CMD_ALLOC)
        begin
            need = ADDR_W'(rsize) + HDR;
            if (!sh_loaded)
            begin
                sh_break = sh_base;
                sh_loaded = 1'b1;
            end
            pick = n;
            min_excess = '0;
            for (int i = 0; i < n; i++)
            begin
                if (sh_size[i] == need)
                begin
                    pick = i;
                    break;
                end
                diff = sh_size[i] - need;
                if (sh_size[i] > need && diff > HDR)
                begin
                    if (sh_fit == FIT_FIRST)
                    begin
                        pick = i;
                        break;
                    end
                    if (pick == n || diff < min_excess)
                    begin
                        pick = i;
                        min_excess = diff;
                    end
                end
            end
            if (pick < n)
            begin
                if (sh_size[pick] == need)
                begin
                    r.payload_addr = sh_start[pick] + HDR;
                    sh_start.delete(pick);
                    sh_size.delete(pick);
                end
                else
                begin
                    sh_size[pick] = sh_size[pick] - need;
                    r.payload_addr = sh_start[pick] + sh_size[pick] + HDR;
                end
                sh_free = sh_free - need;
                r.status = ST_TAKEN;
            end
            else
            begin
                r.payload_addr = sh_break + HDR;
                sh_break = sh_break + need;
                r.status = ST_BREAK;
            end
        end
        else if (n >= MAX_EXTENTS)
            r.status = ST_DROPPED;
        else
        begin
            st = baddr - HDR;
            pos = 0;
            while (pos < n && sh_start[pos] < st)
                pos++;
            sh_start.insert(pos, st);
            sh_size.insert(pos, ADDR_W'(bbytes));
            sh_free = sh_free + ADDR_W'(bbytes);
            if (pos + 1 < sh_start.size() && st + sh_size[pos] == sh_start[pos + 1])
            begin
                sh_size[pos] = sh_size[pos] + sh_size[pos + 1];
                sh_start.delete(pos + 1);
                sh_size.delete(pos + 1);
            end
            if (pos > 0 && sh_start[pos - 1] + sh_size[pos - 1] == st)
            begin
                sh_size[pos - 1] = sh_size[pos - 1] + sh_size[pos];
                sh_start.delete(pos);
                sh_size.delete(pos);
            end
            r.status = ST_FREED;
        end
        r.free_total = sh_free;
        r.used_total = (sh_loaded ? sh_break - sh_base : sh_break) - sh_free;
        return r;
    endfunction

    task automatic send_request(logic cmd, logic [SIZE_W-1:0] rsize,
                                logic [ADDR_W-1:0] baddr, logic [SIZE_W-1:0] bbytes);
        alloc_result_t r;
        int gap;
        gap = $urandom_range(0, 11);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // with no gap, valid stays high into the next request
        repeat (gap)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= cmd;
        req_ch.req_size <= rsize;
        req_ch.block_addr <= baddr;
        req_ch.block_bytes <= bbytes;
        do
            @(posedge clk);
        while (!req_ch.ready);
        r = predict_alloc(cmd, rsize, baddr, bbytes);
        pending_results.push_back(r);
        if (cmd == CMD_ALLOC)
        begin
            live_addr.push_back(r.payload_addr);
            live_bytes.push_back(rsize + SIZE_W'(HEADER_BYTES));
        end
    endtask

    task automatic alloc_bytes(logic [SIZE_W-1:0] rsize);
        send_request(CMD_ALLOC, rsize, $urandom, SIZE_W'($urandom));
    endtask

    // free a random live block, or junk when none is held
    task automatic free_some_block();
        int k;
        if (live_addr.size() == 0)
            send_request(CMD_FREE, SIZE_W'($urandom), $urandom,
                         SIZE_W'($urandom_range(0, 64)));
        else
        begin
            k = $urandom_range(0, live_addr.size() - 1);
            send_request(CMD_FREE, SIZE_W'($urandom), live_addr[k], live_bytes[k]);
            live_addr.delete(k);
            live_bytes.delete(k);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.data <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == CFG_FIT_MODE)
            sh_fit = value[0];
        else
            sh_base = value;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed_edges();
        send_request(CMD_FREE, 24'hFFFFFF, 32'h0000_0020, 24'd32);
        alloc_bytes(24'd0);
        alloc_bytes(24'd0);
        alloc_bytes(24'hFFFFFF);
        send_request(CMD_FREE, 24'd0, 32'hFFFF_FFFF, 24'hFFFFFF);
        send_request(CMD_FREE, 24'd0, 32'h0000_0000, 24'd0);
        send_request(CMD_FREE, 24'd0, 32'h0000_0000, 24'd8);
        alloc_bytes(24'd16);
        alloc_bytes(24'd1);
        for (int i = 0; i < 4; i++)
            free_some_block();
        alloc_bytes(24'd3);
        alloc_bytes(24'hFFFFF0);
    endtask

    task automatic test_split_and_fit();
        for (int i = 0; i < 4; i++)
            alloc_bytes(24'(16 + 48 * i));
        free_some_block();
        free_some_block();
        alloc_bytes(24'd20);
        alloc_bytes(24'd4);
        alloc_bytes(24'd0);
    endtask

    task automatic test_table_full();
        // non-adjacent frees with gaps to fill the table
        logic [ADDR_W-1:0] base;
        base = 32'h4000_0000;
        for (int i = 0; i < MAX_EXTENTS + 3; i++)
            send_request(CMD_FREE, '0, base + 32'(i * 64) + HDR, 24'd32);
        alloc_bytes(24'd16);
        alloc_bytes(24'd0);
        send_request(CMD_FREE, '0, base + 32'h10000, 24'd32);
    endtask

    task automatic test_random_mix(int count);
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 5)
                alloc_bytes(($urandom_range(0, 15) == 0) ? SIZE_W'($urandom) :
                            SIZE_W'($urandom_range(0, 120)));
            else if (kind < 9)
                free_some_block();
            else
                send_request(CMD_FREE, SIZE_W'($urandom), $urandom, SIZE_W'($urandom));
        end
    endtask

    task automatic test_backpressure();
        rsp_hold = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                rsp_hold = 1'b0;
            end
            test_random_mix(12);
        join
    endtask

    // result checker and receiver stalls
    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result addr=%h status=%0d", $time,
                         rsp_ch.payload_addr, rsp_ch.status);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (rsp_ch.payload_addr !== e.payload_addr)
                begin
                    $display("%0t: payload_addr expected %h actual %h", $time,
                             e.payload_addr, rsp_ch.payload_addr);
                    errors++;
                end
                if (rsp_ch.status !== e.status)
                begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             e.status, rsp_ch.status);
                    errors++;
                end
                if (rsp_ch.free_total !== e.free_total)
                begin
                    $display("%0t: free_total expected %h actual %h", $time,
                             e.free_total, rsp_ch.free_total);
                    errors++;
                end
                if (rsp_ch.used_total !== e.used_total)
                begin
                    $display("%0t: used_total expected %h actual %h", $time,
                             e.used_total, rsp_ch.used_total);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int wait_cycles;
        forever
        begin
            wait_cycles = idle_rsp ? $urandom_range(0, 11) : 0;
            rsp_ch.ready <= !rsp_hold && wait_cycles == 0;
            @(posedge clk);
            repeat (wait_cycles) @(posedge clk);
            if (wait_cycles != 0 && !rsp_hold)
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        errors = 0;
        rsp_hold = 1'b0;
        idle_rsp = 1'b1;
        sh_break = '0;
        sh_loaded = 1'b0;
        sh_free = '0;
        sh_fit = 1'b0;
        sh_base = '0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = CMD_ALLOC;
        req_ch.req_size = '0;
        req_ch.block_addr = '0;
        req_ch.block_bytes = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = CFG_FIT_MODE;
        cfg_ch.data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        drain_results();
        write_config(CFG_HEAP_BASE, 32'hFFFF_FF00);
        write_config(CFG_FIT_MODE, 32'd1);
        test_split_and_fit();
        test_table_full();
        test_backpressure();
        drain_results();
        write_config(CFG_HEAP_BASE, 32'h1000_0000);
        idle_rsp = 1'b0;
        test_random_mix(250);
        idle_rsp = 1'b1;
        drain_results();
        write_config(CFG_FIT_MODE, 32'd0);
        write_config(CFG_HEAP_BASE, $urandom);
        test_random_mix(350);
        drain_results();
        write_config(CFG_FIT_MODE, 32'd1);
        write_config(CFG_HEAP_BASE, 32'h0000_0000);
        test_random_mix(350);
        drain_results();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
